[rtl/core/itrs_pkg.sv]
package itrs_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] TEN_BASE  = 6'd10;

    localparam logic [CHAR_W-1:0] MINUS_CHAR  = 8'h2D;
    localparam logic [CHAR_W-1:0] NUL_CHAR    = 8'h00;
    localparam logic [CHAR_W-1:0] ZERO_CHAR   = 8'h30;
    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'h57;

    // digit value 0..35 to lower-case ascii
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (d < TEN_BASE) begin
            return ZERO_CHAR + dw;
        end else begin
            return LETTER_BASE + dw;
        end
    endfunction

endpackage

[rtl/core/integer_to_radix_string.sv]
// channel | dir | tdata (low bit up)                          | tlast | tuser
// s_      | in  | value[VALUE_BITS], radix[6], zero pad to byte | -     | -
// m_      | out | char_code[8]                                 | last  | bad_radix
//
// each digit is the remainder of a shared one-bit restoring divider run over all VALUE_BITS bits
// an item with n digits is divided n times, then sends a minus sign for a negative radix 10 value,
// the n digits and a closing nul; output stalls hold each character
// a bad radix answers with a single nul in the cycle after the request
// digits are kept in a small memory and read back most significant first
// reset clears the sequencer and output valid; the digit memory is not cleared
// s_tready is high only while idle; output stalls hold the sequencer in place
module integer_to_radix_string
    import itrs_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // value, radix
    input  logic [((VALUE_BITS+RADIX_W+7)/8)*8-1:0]       s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // char_code
    output logic [CHAR_W-1:0]                             m_tdata,
    output logic                                          m_tlast,
    // bad_radix
    output logic                                          m_tuser
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_FETCH,
        ST_SHOW,
        ST_NUL
    } state_t;

    state_t                 state_reg;
    logic [VALUE_BITS-1:0]  quo_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [RADIX_W-1:0]     radix_reg;
    logic                   neg_reg;
    logic [IDX_W-1:0]       bit_cnt_reg;
    logic [CNT_W-1:0]       ndig_reg;
    logic                   m_tvalid_reg;
    logic [CHAR_W-1:0]      m_tdata_reg;
    logic                   m_tlast_reg;
    logic                   m_tuser_reg;

    logic [CHAR_W-1:0]      dig_mem [VALUE_BITS];

    logic [VALUE_BITS-1:0]  in_value;
    logic [RADIX_W-1:0]     in_radix;
    logic                   in_bad;
    logic                   in_neg10;
    logic [RADIX_W:0]       shifted;
    logic [RADIX_W-1:0]     diff;
    logic                   ge;
    logic [RADIX_W-1:0]     rem_next;
    logic [VALUE_BITS-1:0]  quo_next;
    logic                   div_last;
    logic [CNT_W-1:0]       ndig_inc;
    logic [CNT_W-1:0]       ndig_dec;
    logic                   div_done;
    logic                   out_take;

    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign in_radix = s_tdata[VALUE_BITS +: RADIX_W];
    assign in_bad   = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
    assign in_neg10 = in_value[VALUE_BITS-1] && (in_radix == TEN_BASE);

    // one restoring division step: next quotient bit and partial remainder
    assign shifted  = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff     = shifted[RADIX_W-1:0] - radix_reg;
    assign ge       = shifted >= {1'b0, radix_reg};
    assign rem_next = ge ? diff : shifted[RADIX_W-1:0];
    assign quo_next = {quo_reg[VALUE_BITS-2:0], ge};

    assign div_last = bit_cnt_reg == IDX_W'(VALUE_BITS - 1);
    assign ndig_inc = ndig_reg + 1'b1;
    assign ndig_dec = ndig_reg - 1'b1;
    assign div_done = (quo_next == '0) || (ndig_inc == CNT_W'(VALUE_BITS));
    assign out_take = m_tvalid_reg && m_tready;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV && div_last) begin
            dig_mem[ndig_reg[IDX_W-1:0]] <= digit_char(rem_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            quo_reg      <= '0;
            rem_reg      <= '0;
            radix_reg    <= '0;
            neg_reg      <= 1'b0;
            bit_cnt_reg  <= '0;
            ndig_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= NUL_CHAR;
            m_tlast_reg  <= 1'b0;
            m_tuser_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        radix_reg   <= in_radix;
                        neg_reg     <= in_neg10;
                        quo_reg     <= in_neg10 ? ('0 - in_value) : in_value;
                        rem_reg     <= '0;
                        bit_cnt_reg <= '0;
                        ndig_reg    <= '0;
                        if (in_bad) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= NUL_CHAR;
                            m_tlast_reg  <= 1'b1;
                            m_tuser_reg  <= 1'b1;
                            state_reg    <= ST_NUL;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_last) begin
                        ndig_reg    <= ndig_inc;
                        rem_reg     <= '0;
                        bit_cnt_reg <= '0;
                        quo_reg     <= quo_next;
                        if (div_done) begin
                            if (neg_reg) begin
                                m_tvalid_reg <= 1'b1;
                                m_tdata_reg  <= MINUS_CHAR;
                                m_tlast_reg  <= 1'b0;
                                m_tuser_reg  <= 1'b0;
                                state_reg    <= ST_SIGN;
                            end else begin
                                state_reg <= ST_FETCH;
                            end
                        end
                    end else begin
                        rem_reg     <= rem_next;
                        quo_reg     <= quo_next;
                        bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    end
                end
                ST_SIGN: begin
                    if (out_take) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    // digits come back in reverse order of division
                    m_tdata_reg  <= dig_mem[ndig_dec[IDX_W-1:0]];
                    m_tvalid_reg <= 1'b1;
                    m_tlast_reg  <= 1'b0;
                    m_tuser_reg  <= 1'b0;
                    ndig_reg     <= ndig_dec;
                    state_reg    <= ST_SHOW;
                end
                ST_SHOW: begin
                    if (out_take) begin
                        if (ndig_reg == '0) begin
                            m_tdata_reg <= NUL_CHAR;
                            m_tlast_reg <= 1'b1;
                            m_tuser_reg <= 1'b0;
                            state_reg   <= ST_NUL;
                        end else begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= ST_FETCH;
                        end
                    end
                end
                ST_NUL: begin
                    if (out_take) begin
                        m_tvalid_reg <= 1'b0;
                        m_tlast_reg  <= 1'b0;
                        m_tuser_reg  <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/itrs_checker.sv]
module itrs_checker
    import itrs_pkg::*;
(
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [CHAR_W-1:0]                       m_tdata,
    input logic                                    m_tlast,
    input logic                                    m_tuser
);

    // no result is shown while the block waits for a request
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("result valid while idle");

    // one request at a time
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after a request");

    // the run ends in a nul
    a_last_is_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == NUL_CHAR)
        else $error("last item is not nul");

    // an error flag only rides on the last item of a run
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("bad radix flag on a text character");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind integer_to_radix_string itrs_checker u_itrs_checker (.*);
